### rtl/dial_pattern_matcher_defines.svh
// Assertion macros for the dial pattern matcher.
// Used by rtl/dial_pattern_matcher.sv; expects clk and rst_n in scope.
`ifndef DIAL_PATTERN_MATCHER_DEFINES_SVH
`define DIAL_PATTERN_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF

`define DPM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dial_pattern_matcher: invariant violated");

`define DPM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dial_pattern_matcher: implication violated");

`define DPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dial_pattern_matcher: next-cycle check violated");

`else

`define DPM_ASSERT_ALWAYS(label, cond)
`define DPM_ASSERT_IMPLY(label, ante, cons)
`define DPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/dpm_pkg.sv
// Shared types and constants for the dial pattern matcher.
// No dependencies; used by dpm_step and dial_pattern_matcher.
package dpm_pkg;

    localparam int MAX_PATTERN_CHARS_DEFAULT = 16;
    localparam int POS_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 64;
    localparam int LEN_W   = 5;
    localparam int INDEX_W = 2;

    localparam logic [CHAR_W-1:0] CH_ANY_DIGIT = 8'h78;  // 'x'
    localparam logic [CHAR_W-1:0] CH_NONZERO   = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CH_TWO_UP    = 8'h6E;  // 'n'
    localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_BANG      = 8'h21;  // '!'
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_ONE       = 8'h31;  // '1'
    localparam logic [CHAR_W-1:0] CH_TWO       = 8'h32;  // '2'
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;  // '9'

    typedef enum logic [INDEX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             mismatch;
        logic             absorbed;
    } match_state_t;

    function automatic logic in_range(
        input logic [CHAR_W-1:0] c,
        input logic [CHAR_W-1:0] lo,
        input logic [CHAR_W-1:0] hi
    );
        return (c >= lo) && (c <= hi);
    endfunction

endpackage

### rtl/dpm_step.sv
// One character step of the dial pattern matcher: next match state and end result.
// Depends on dpm_pkg.
module dpm_step
    import dpm_pkg::*;
#(
    parameter int MAX_PATTERN_CHARS = MAX_PATTERN_CHARS_DEFAULT
) (
    input  logic [WORD_W-1:0] pat_low,
    input  logic [WORD_W-1:0] pat_high,
    input  logic [LEN_W-1:0]  pat_len,
    input  match_state_t      cur,
    input  logic [CHAR_W-1:0] symbol,
    input  logic              is_end,
    output match_state_t      nxt,
    output logic              ok
);

    logic [2*WORD_W-1:0] pat_all;
    logic [LEN_W-1:0]    len_clamped;
    logic [POS_W-1:0]    pat_end;
    logic [CHAR_W-1:0]   pchar;
    logic                used_up;
    logic                good;
    logic                take_rest;

    assign pat_all     = {pat_high, pat_low};
    assign len_clamped = (pat_len > LEN_W'(MAX_PATTERN_CHARS)) ?
                         LEN_W'(MAX_PATTERN_CHARS) : pat_len;

    // first zero byte inside the used length ends the pattern
    always_comb
    begin
        pat_end = POS_W'(len_clamped);
        for (int i = MAX_PATTERN_CHARS - 1; i >= 0; i--)
        begin
            if ((pat_all[i*CHAR_W +: CHAR_W] == '0) && (LEN_W'(i) < len_clamped))
            begin
                pat_end = POS_W'(i);
            end
        end
    end

    assign pchar   = pat_all[cur.pos[3:0]*CHAR_W +: CHAR_W];
    assign used_up = (cur.pos >= pat_end);

    always_comb
    begin
        good      = 1'b0;
        take_rest = 1'b0;
        case (pchar)
            CH_ANY_DIGIT: good = in_range(symbol, CH_ZERO, CH_NINE);
            CH_NONZERO:   good = in_range(symbol, CH_ONE, CH_NINE);
            CH_TWO_UP:    good = in_range(symbol, CH_TWO, CH_NINE);
            CH_DOT:
            begin
                good      = in_range(symbol, CH_ZERO, CH_NINE);
                take_rest = good;
            end
            CH_BANG:
            begin
                good      = 1'b1;
                take_rest = 1'b1;
            end
            default:      good = (pchar == symbol);
        endcase
    end

    assign ok = !cur.mismatch && (used_up || (pchar == CH_BANG));

    always_comb
    begin
        nxt = cur;
        if (is_end)
        begin
            nxt = '0;
        end
        else if (cur.mismatch || cur.absorbed)
        begin
            nxt = cur;
        end
        else if (used_up)
        begin
            nxt.mismatch = 1'b1;
        end
        else if (!good)
        begin
            nxt.mismatch = 1'b1;
        end
        else
        begin
            nxt.pos      = cur.pos + POS_W'(1);
            nxt.absorbed = take_rest;
        end
    end

endmodule

### rtl/dial_pattern_matcher.sv
// Top level of the dial pattern matcher: config registers, match state, result register.
// Depends on dpm_pkg, dpm_step and dial_pattern_matcher_defines.svh.
//
//  channel   handshake             payload
//  sym       sym_valid/sym_ready   symbol[7:0], is_end
//  res       res_valid/res_ready   matched
//  cfg       cfg_valid/cfg_ready   cfg_index[1:0], cfg_data[63:0]
//
// One request per cycle; the match state updates at the accepting edge.
// An end request loads the result register; matched appears the next cycle.
// Any request, character or end, stalls only while the result register is
// full and res_ready is low. cfg_ready is always high.
// Reset clears the pattern, the match state and the result valid.
`include "dial_pattern_matcher_defines.svh"

module dial_pattern_matcher
    import dpm_pkg::*;
#(
    parameter int MAX_PATTERN_CHARS = MAX_PATTERN_CHARS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    output logic                sym_ready,
    input  logic [CHAR_W-1:0]   symbol,
    input  logic                is_end,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                matched,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]   cfg_data
);

    logic [WORD_W-1:0] pat_low_reg;
    logic [WORD_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    match_state_t      state_reg;
    match_state_t      state_next;
    logic              res_valid_reg;
    logic              matched_reg;
    logic              step_ok;
    logic              sym_take;

    assign cfg_ready = 1'b1;
    assign sym_ready = !res_valid_reg || res_ready;
    assign sym_take  = sym_valid && sym_ready;
    assign res_valid = res_valid_reg;
    assign matched   = matched_reg;

    dpm_step #(
        .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS)
    ) u_step (
        .pat_low  (pat_low_reg),
        .pat_high (pat_high_reg),
        .pat_len  (pat_len_reg),
        .cur      (state_reg),
        .symbol   (symbol),
        .is_end   (is_end),
        .nxt      (state_next),
        .ok       (step_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sym_take)
            begin
                state_reg <= state_next;
            end
            if (sym_take && is_end)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_take && is_end)
        begin
            matched_reg <= step_ok;
        end
    end

    `DPM_ASSERT_ALWAYS(a_pos_bound, state_reg.pos <= POS_W'(MAX_PATTERN_CHARS))
    `DPM_ASSERT_ALWAYS(a_not_both, !(state_reg.mismatch && state_reg.absorbed))
    `DPM_ASSERT_NEXT(a_end_clears, sym_take && is_end, state_reg == '0)
    `DPM_ASSERT_NEXT(a_end_result, sym_take && is_end, res_valid)
    `DPM_ASSERT_NEXT(a_done_holds, sym_take && !is_end && (state_reg.mismatch || state_reg.absorbed), $stable(state_reg))

endmodule
